/* rtl/rc4_pkg.sv */
// Shared definitions for the RC4 stream cipher engine.
// Holds the key length limit and the command and status bundles
// passed between rc4_ctrl and rc4_dp. Depends on nothing.
package rc4_pkg;

	localparam int unsigned KEY_MAX = 256;
	localparam int unsigned CNT_W   = 9;

	typedef struct packed {
		logic load_in;
		logic key_wr;
		logic init_start;
		logic init_wr;
		logic ks_rd;
		logic ks_j;
		logic ks_w1;
		logic ks_w2;
		logic d_ri;
		logic d_rj;
		logic d_w1;
		logic d_w2;
		logic out_ks;
		logic out_pass;
	} rc4_cmd_t;

	typedef struct packed {
		logic last;
		logic k_last;
		logic out_free;
	} rc4_sts_t;

endpackage

/* rtl/rc4_dp.sv */
// Datapath of the RC4 engine: key store, permutation memory, indices
// and the output register. Driven by rc4_ctrl commands; uses rc4_pkg.
module rc4_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  rc4_pkg::rc4_cmd_t cmd,
	output rc4_pkg::rc4_sts_t sts,
	input  logic [7:0]        byte_in,
	input  logic              last,
	output logic [7:0]        byte_out,
	output logic              last_out,
	output logic              keyed,
	output logic              out_valid,
	input  logic              out_ready
);

	localparam logic [1:0] FWD_MEM = 2'd0;
	localparam logic [1:0] FWD_SI  = 2'd1;
	localparam logic [1:0] FWD_SJ  = 2'd2;

	logic [7:0] key_mem [256];
	logic [7:0] perm_mem [256];

	logic [7:0] byte_q;
	logic       last_q;
	logic [rc4_pkg::CNT_W-1:0] key_count_q;
	logic [7:0] kidx_q;
	logic [7:0] key_rd_q;
	logic [7:0] perm_rd_q;
	logic [7:0] k_q;
	logic [7:0] i_q;
	logic [7:0] j_q;
	logic [7:0] si_q;
	logic [7:0] sj_q;
	logic [1:0] fwd_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_keyed_q;
	logic       out_valid_q;

	logic       perm_we;
	logic [7:0] perm_wa;
	logic [7:0] perm_wd;
	logic       perm_re;
	logic [7:0] perm_ra;
	logic [7:0] jn_ks;
	logic [7:0] jn_d;
	logic [7:0] t_idx;
	logic [7:0] ks_byte;
	logic       key_room;
	logic       out_free;

	assign jn_ks    = j_q + key_rd_q + perm_rd_q;
	assign jn_d     = j_q + perm_rd_q;
	assign t_idx    = si_q + perm_rd_q;
	assign key_room = key_count_q < rc4_pkg::CNT_W'(rc4_pkg::KEY_MAX);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		case (fwd_q)
			FWD_SI:  ks_byte = si_q;
			FWD_SJ:  ks_byte = sj_q;
			default: ks_byte = perm_rd_q;
		endcase
	end

	always_comb begin
		perm_we = 1'b1;
		perm_wa = k_q;
		perm_wd = k_q;
		if (cmd.init_wr) begin
			perm_wa = k_q;
			perm_wd = k_q;
		end else if (cmd.ks_w1) begin
			perm_wa = k_q;
			perm_wd = perm_rd_q;
		end else if (cmd.d_w1) begin
			perm_wa = i_q;
			perm_wd = perm_rd_q;
		end else if (cmd.ks_w2 || cmd.d_w2) begin
			perm_wa = j_q;
			perm_wd = si_q;
		end else begin
			perm_we = 1'b0;
		end
	end

	always_comb begin
		perm_re = 1'b1;
		perm_ra = k_q;
		if (cmd.ks_rd) begin
			perm_ra = k_q;
		end else if (cmd.ks_j) begin
			perm_ra = jn_ks;
		end else if (cmd.d_ri) begin
			perm_ra = i_q + 8'd1;
		end else if (cmd.d_rj) begin
			perm_ra = jn_d;
		end else if (cmd.d_w1) begin
			perm_ra = t_idx;
		end else begin
			perm_re = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (perm_we) begin
			perm_mem[perm_wa] <= perm_wd;
		end
		if (perm_re) begin
			perm_rd_q <= perm_mem[perm_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.key_wr && key_room) begin
			key_mem[key_count_q[7:0]] <= byte_q;
		end
		if (cmd.ks_rd) begin
			key_rd_q <= key_mem[kidx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			byte_q <= byte_in;
			last_q <= last;
		end
		if (cmd.ks_j) begin
			si_q <= perm_rd_q;
		end
		if (cmd.d_rj) begin
			si_q <= perm_rd_q;
		end
		if (cmd.d_w1) begin
			sj_q <= perm_rd_q;
			if (t_idx == j_q) begin
				fwd_q <= FWD_SI;
			end else if (t_idx == i_q) begin
				fwd_q <= FWD_SJ;
			end else begin
				fwd_q <= FWD_MEM;
			end
		end
		if (cmd.out_ks) begin
			out_byte_q  <= byte_q ^ ks_byte;
			out_last_q  <= last_q;
			out_keyed_q <= 1'b1;
		end else if (cmd.out_pass) begin
			out_byte_q  <= byte_q;
			out_last_q  <= last_q;
			out_keyed_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
			kidx_q      <= '0;
			k_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.key_wr && key_room) begin
				key_count_q <= key_count_q + rc4_pkg::CNT_W'(1);
			end
			if (cmd.init_start) begin
				k_q    <= '0;
				kidx_q <= '0;
				j_q    <= '0;
			end
			if (cmd.init_wr) begin
				k_q <= k_q + 8'd1;
			end
			if (cmd.ks_j) begin
				j_q <= jn_ks;
			end
			if (cmd.ks_w2) begin
				k_q <= k_q + 8'd1;
				if (rc4_pkg::CNT_W'(kidx_q) + rc4_pkg::CNT_W'(1) == key_count_q) begin
					kidx_q <= '0;
				end else begin
					kidx_q <= kidx_q + 8'd1;
				end
				if (k_q == 8'd255) begin
					i_q         <= '0;
					j_q         <= '0;
					key_count_q <= '0;
				end
			end
			if (cmd.d_ri) begin
				i_q <= i_q + 8'd1;
			end
			if (cmd.d_rj) begin
				j_q <= jn_d;
			end
			if (cmd.out_ks || cmd.out_pass) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.last     = last_q;
	assign sts.k_last   = k_q == 8'd255;
	assign sts.out_free = out_free;

	assign byte_out  = out_byte_q;
	assign last_out  = out_last_q;
	assign keyed     = out_keyed_q;
	assign out_valid = out_valid_q;

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q <= rc4_pkg::CNT_W'(rc4_pkg::KEY_MAX))
		else $error("key count beyond limit");

	a_kidx_in_key: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ks_rd |-> rc4_pkg::CNT_W'(kidx_q) < key_count_q)
		else $error("key index outside stored key");

	a_sched_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ks_w2 && k_q == 8'd255) |=> (i_q == 8'd0 && j_q == 8'd0 && key_count_q == '0))
		else $error("indices not cleared after key schedule");

endmodule

/* rtl/rc4_ctrl.sv */
// Controller state machine of the RC4 engine: input handshake, key
// schedule sequencing and keystream steps. Uses rc4_pkg types.
module rc4_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  rc4_pkg::rc4_sts_t sts,
	output rc4_pkg::rc4_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_KEY   = 4'd1;
	localparam logic [3:0] ST_INIT  = 4'd2;
	localparam logic [3:0] ST_KS_RD = 4'd3;
	localparam logic [3:0] ST_KS_J  = 4'd4;
	localparam logic [3:0] ST_KS_W1 = 4'd5;
	localparam logic [3:0] ST_KS_W2 = 4'd6;
	localparam logic [3:0] ST_D_RI  = 4'd7;
	localparam logic [3:0] ST_D_RJ  = 4'd8;
	localparam logic [3:0] ST_D_W1  = 4'd9;
	localparam logic [3:0] ST_D_W2  = 4'd10;
	localparam logic [3:0] ST_PASS  = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       keyed_q;
	logic       keyed_d;

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		state_d = state_q;
		keyed_d = keyed_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					if (!kind) begin
						state_d = ST_KEY;
					end else if (keyed_q) begin
						state_d = ST_D_RI;
					end else begin
						state_d = ST_PASS;
					end
				end
			end
			ST_KEY: begin
				cmd.key_wr = 1'b1;
				if (sts.last) begin
					cmd.init_start = 1'b1;
					state_d        = ST_INIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.k_last) begin
					state_d = ST_KS_RD;
				end
			end
			ST_KS_RD: begin
				cmd.ks_rd = 1'b1;
				state_d   = ST_KS_J;
			end
			ST_KS_J: begin
				cmd.ks_j = 1'b1;
				state_d  = ST_KS_W1;
			end
			ST_KS_W1: begin
				cmd.ks_w1 = 1'b1;
				state_d   = ST_KS_W2;
			end
			ST_KS_W2: begin
				cmd.ks_w2 = 1'b1;
				if (sts.k_last) begin
					keyed_d = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_KS_RD;
				end
			end
			ST_D_RI: begin
				cmd.d_ri = 1'b1;
				state_d  = ST_D_RJ;
			end
			ST_D_RJ: begin
				cmd.d_rj = 1'b1;
				state_d  = ST_D_W1;
			end
			ST_D_W1: begin
				cmd.d_w1 = 1'b1;
				state_d  = ST_D_W2;
			end
			ST_D_W2: begin
				cmd.d_w2 = 1'b1;
				if (sts.out_free) begin
					cmd.out_ks = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_PASS: begin
				if (sts.out_free) begin
					cmd.out_pass = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			keyed_q <= 1'b0;
		end else begin
			state_q <= state_d;
			keyed_q <= keyed_d;
		end
	end

	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_ks || cmd.out_pass) |-> sts.out_free)
		else $error("result loaded over a waiting beat");

	a_keyed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		keyed_q |=> keyed_q)
		else $error("keyed flag dropped");

	a_pass_unkeyed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_pass |-> !keyed_q)
		else $error("pass-through while keyed");

endmodule

/* rtl/rc4_stream_cipher.sv */
// Top level of the RC4 stream cipher engine.
// Instantiates rc4_ctrl and rc4_dp; uses rc4_pkg.
//
// Input channel (in_valid/in_ready) carries kind, byte_in and last. A key
// beat (kind 0) is stored in the key store and gives no result; a key beat
// with last set starts the key schedule. A data beat (kind 1) gives one
// output beat (byte_out, last_out, keyed) on out_valid/out_ready.
// The engine works on one beat at a time; in_ready is high only when idle.
// Key beat: stored in the KEY state, then in_ready returns in IDLE.
// Last key beat: the 256-entry permutation fill in INIT, then the 256
// schedule steps (KS_RD, KS_J, KS_W1, KS_W2) on the permutation RAM.
// Keyed data beat: states D_RI, D_RJ, D_W1 and D_W2 do the three dependent
// RAM reads and two writes of one keystream step; the result is registered
// in D_W2 when the output is free. Unkeyed data beat: passed unchanged.
// A finished result waits in the output register while the next beat is
// accepted; if the receiver stalls, the following result holds the engine
// in its last step until the register frees. Reset clears the indices, the
// key count and the keyed flag; the key and permutation RAMs are not cleared.
module rc4_stream_cipher (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [7:0] byte_in,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] byte_out,
	output logic       last_out,
	output logic       keyed
);

	rc4_pkg::rc4_cmd_t cmd;
	rc4_pkg::rc4_sts_t sts;

	rc4_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.sts      (sts),
		.cmd      (cmd)
	);

	rc4_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.byte_in   (byte_in),
		.last      (last),
		.byte_out  (byte_out),
		.last_out  (last_out),
		.keyed     (keyed),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule
